/* sv/sct_pkg.sv */
package sct_pkg;

  // Widths of the position counters and of the item fields.
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int CP_BITS     = 21;
  localparam int LEN_BITS    = 16;
  localparam int KW_LEN      = 6;

  typedef logic [CP_BITS-1:0]     cp_t;
  typedef logic [LINE_BITS-1:0]   line_t;
  typedef logic [COLUMN_BITS-1:0] col_t;
  typedef logic [LEN_BITS-1:0]    len_t;

  // Token kinds as carried on the output tuser.
  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_PUNCT   = 4'd1,
    KIND_ARROW   = 4'd2,
    KIND_STR_END = 4'd3,
    KIND_BAD_STR = 4'd4,
    KIND_RETURN  = 4'd5,
    KIND_EXTERN  = 4'd6,
    KIND_ATOM    = 4'd7,
    KIND_UNPARS  = 4'd8,
    KIND_SBYTE   = 4'd9,
    KIND_WCHAR   = 4'd10,
    KIND_WIDE    = 4'd11
  } kind_t;

  // Scanner modes, one-hot.
  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_MINUS  = 6'b000010,
    MODE_CPEND  = 6'b000100,
    MODE_WORD   = 6'b001000,
    MODE_STR    = 6'b010000,
    MODE_STRESC = 6'b100000
  } mode_t;

  // One result item.
  typedef struct packed {
    kind_t kind;
    cp_t   value;
    line_t start_line;
    col_t  start_col;
    line_t end_line;
    col_t  end_col;
  } res_t;

  // Characters the scanner looks for.
  localparam cp_t CP_TAB    = 21'h09;
  localparam cp_t CP_NL     = 21'h0A;
  localparam cp_t CP_CR     = 21'h0D;
  localparam cp_t CP_SPACE  = 21'h20;
  localparam cp_t CP_QUOTE  = 21'h22;
  localparam cp_t CP_LPAREN = 21'h28;
  localparam cp_t CP_RPAREN = 21'h29;
  localparam cp_t CP_PLUS   = 21'h2B;
  localparam cp_t CP_COMMA  = 21'h2C;
  localparam cp_t CP_MINUS  = 21'h2D;
  localparam cp_t CP_ZERO   = 21'h30;
  localparam cp_t CP_NINE   = 21'h39;
  localparam cp_t CP_COLON  = 21'h3A;
  localparam cp_t CP_SEMI   = 21'h3B;
  localparam cp_t CP_GT     = 21'h3E;
  localparam cp_t CP_UPPER_A = 21'h41;
  localparam cp_t CP_UPPER_Z = 21'h5A;
  localparam cp_t CP_BSLASH = 21'h5C;
  localparam cp_t CP_USCORE = 21'h5F;
  localparam cp_t CP_LOWER_A = 21'h61;
  localparam cp_t CP_C      = 21'h63;
  localparam cp_t CP_N      = 21'h6E;
  localparam cp_t CP_R      = 21'h72;
  localparam cp_t CP_T      = 21'h74;
  localparam cp_t CP_LOWER_Z = 21'h7A;
  localparam cp_t CP_LBRACE = 21'h7B;
  localparam cp_t CP_RBRACE = 21'h7D;
  localparam cp_t CP_WIDE   = 21'h100;

  // Keyword spellings, first character at index 0.
  localparam logic [7:0] KW_RETURN [KW_LEN] = '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E};
  localparam logic [7:0] KW_EXTERN [KW_LEN] = '{8'h65, 8'h78, 8'h74, 8'h65, 8'h72, 8'h6E};

  function automatic logic is_space(input cp_t c);
    return (c == CP_SPACE) || (c >= CP_TAB && c <= CP_CR);
  endfunction

  function automatic logic is_alpha(input cp_t c);
    return (c >= CP_LOWER_A && c <= CP_LOWER_Z) || (c >= CP_UPPER_A && c <= CP_UPPER_Z);
  endfunction

  function automatic logic is_wordc(input cp_t c);
    return (c == CP_USCORE) || is_alpha(c) || (c >= CP_ZERO && c <= CP_NINE);
  endfunction

  function automatic logic is_punct(input cp_t c);
    return (c == CP_LPAREN) || (c == CP_RPAREN) || (c == CP_LBRACE) ||
           (c == CP_RBRACE) || (c == CP_COMMA) || (c == CP_PLUS) ||
           (c == CP_SEMI) || (c == CP_COLON);
  endfunction

  function automatic len_t len_inc(input len_t l);
    return (l != '1) ? l + len_t'(1) : l;
  endfunction

  // Keyword match flags after one more word character (bit 0 return, bit 1 extern).
  function automatic logic [1:0] kw_update(input len_t l, input logic [1:0] f, input cp_t c);
    logic [1:0] r;
    r = f;
    if (l < len_t'(KW_LEN)) begin
      if (c != cp_t'(KW_RETURN[l[2:0]])) r[0] = 1'b0;
      if (c != cp_t'(KW_EXTERN[l[2:0]])) r[1] = 1'b0;
    end else begin
      r = 2'b00;
    end
    return r;
  endfunction

  function automatic res_t mk_res(input kind_t k, input cp_t v, input line_t sl,
                                  input col_t sc, input line_t el, input col_t ec);
    res_t r;
    r.kind       = k;
    r.value      = v;
    r.start_line = sl;
    r.start_col  = sc;
    r.end_line   = el;
    r.end_col    = ec;
    return r;
  endfunction

endpackage

/* sv/source_code_tokenizer.sv */
// An item is accepted into the input register; its results are loaded into the result group
// register, from which they are offered. Reset clears all control state at once.
// Throughput: one item per cycle while each item gives at most one result and m_tready
// is high; an item with several results (at most three) keeps the next item waiting in
// the input register while the results drain one a cycle.
module source_code_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // codepoint [20:0], zero padding [23:21]
  input  logic        s_tuser,   // at_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // value, start_line, start_col, end_line, end_col, padding
  output logic [3:0]  m_tuser,   // kind
  output logic        m_tlast    // last result of its input item
);
  import sct_pkg::*;

  localparam int NRES = 3;

  // Input register.
  logic  in_valid;
  cp_t   in_cp;
  logic  in_end;

  // Scanner state.
  mode_t      lex_mode, lex_mode_next;
  line_t      line_count, line_count_next;
  col_t       column_count, column_count_next;
  line_t      tok_line, tok_line_next;
  col_t       tok_col, tok_col_next;
  len_t       content_length, content_length_next;
  logic [1:0] kw_flags, kw_flags_next;

  // Result group register.
  res_t       grp [NRES];
  logic       grp_valid;
  logic [1:0] grp_cnt;
  logic [1:0] grp_idx;

  res_t       res [NRES];
  logic [1:0] res_n;

  logic grp_free;
  logic process;
  res_t cur;

  // Handshake between the input register and the result group.
  assign cur      = grp[grp_idx];
  assign m_tvalid = grp_valid;
  assign m_tlast  = (grp_idx == grp_cnt - 2'd1);
  assign m_tuser  = cur.kind;
  assign m_tdata  = {3'b000, cur.end_col, cur.end_line, cur.start_col, cur.start_line,
                     cur.value};
  assign grp_free = !grp_valid || (m_tready && m_tlast);
  assign process  = in_valid && grp_free;
  assign s_tready = !in_valid || process;

  // One scanning step for the item in the input register.
  always_comb begin : scan_step
    logic done;
    cp_t  v;
    lex_mode_next       = lex_mode;
    line_count_next     = line_count;
    column_count_next   = column_count;
    tok_line_next       = tok_line;
    tok_col_next        = tok_col;
    content_length_next = content_length;
    kw_flags_next       = kw_flags;
    res_n               = 2'd0;
    done                = 1'b0;
    v                   = in_cp;
    for (int i = 0; i < NRES; i++) res[i] = '0;

    // Inside a string or just after a backslash.
    if (lex_mode == MODE_STR || lex_mode == MODE_STRESC) begin
      if (in_end) begin
        res[res_n] = mk_res(KIND_BAD_STR, '0, tok_line, tok_col,
                            line_count_next, column_count_next);
        res_n = res_n + 2'd1;
        lex_mode_next = MODE_IDLE;
      end else begin
        if (column_count_next != '1) column_count_next = column_count_next + col_t'(1);
        if (in_cp == CP_NL) begin
          if (line_count_next != '1) line_count_next = line_count_next + line_t'(1);
          column_count_next = '0;
        end
        if (lex_mode == MODE_STRESC || (in_cp != CP_QUOTE && in_cp != CP_BSLASH)) begin
          if (lex_mode == MODE_STRESC) begin
            priority if (in_cp == CP_T)    v = CP_TAB;
            else if (in_cp == CP_N)        v = CP_NL;
            else if (in_cp == CP_R)        v = CP_CR;
            else if (in_cp == CP_ZERO)     v = '0;
            else                           v = in_cp;
          end
          if (v >= CP_WIDE) begin
            res[res_n] = mk_res(KIND_WIDE, v, tok_line, tok_col,
                                line_count_next, column_count_next);
          end else begin
            content_length_next = len_inc(content_length_next);
            res[res_n] = mk_res(KIND_SBYTE, v, tok_line, tok_col,
                                line_count_next, column_count_next);
          end
          res_n = res_n + 2'd1;
          lex_mode_next = MODE_STR;
        end else if (in_cp == CP_QUOTE) begin
          res[res_n] = mk_res(KIND_STR_END, cp_t'(content_length_next), tok_line, tok_col,
                              line_count_next, column_count_next);
          res_n = res_n + 2'd1;
          lex_mode_next = MODE_IDLE;
        end else begin
          lex_mode_next = MODE_STRESC;
        end
        done = 1'b1;
      end
    end

    // A minus waiting to see whether an arrow follows.
    if (!done && lex_mode_next == MODE_MINUS) begin
      lex_mode_next = MODE_IDLE;
      if (!in_end && in_cp == CP_GT) begin
        if (column_count_next != '1) column_count_next = column_count_next + col_t'(1);
        res[res_n] = mk_res(KIND_ARROW, '0, tok_line, tok_col,
                            line_count_next, column_count_next);
        res_n = res_n + 2'd1;
        done = 1'b1;
      end else begin
        res[res_n] = mk_res(KIND_PUNCT, CP_MINUS, tok_line, tok_col,
                            line_count_next, column_count_next);
        res_n = res_n + 2'd1;
      end
    end

    // A c waiting to see whether a string opens.
    if (!done && lex_mode_next == MODE_CPEND) begin
      content_length_next = '0;
      if (!in_end && in_cp == CP_QUOTE) begin
        if (column_count_next != '1) column_count_next = column_count_next + col_t'(1);
        lex_mode_next = MODE_STR;
        done = 1'b1;
      end else begin
        kw_flags_next = kw_update('0, 2'b11, CP_C);
        content_length_next = len_t'(1);
        res[res_n] = mk_res(KIND_WCHAR, CP_C, tok_line, tok_col,
                            line_count_next, column_count_next);
        res_n = res_n + 2'd1;
        lex_mode_next = MODE_WORD;
      end
    end

    // Inside a word.
    if (!done && lex_mode_next == MODE_WORD) begin
      if (!in_end && is_wordc(in_cp)) begin
        if (column_count_next != '1) column_count_next = column_count_next + col_t'(1);
        kw_flags_next = kw_update(content_length_next, kw_flags_next, in_cp);
        content_length_next = len_inc(content_length_next);
        res[res_n] = mk_res(KIND_WCHAR, in_cp, tok_line, tok_col,
                            line_count_next, column_count_next);
        res_n = res_n + 2'd1;
        done = 1'b1;
      end else begin
        priority if (content_length_next == len_t'(KW_LEN) && kw_flags_next[0])
          res[res_n] = mk_res(KIND_RETURN, '0, tok_line, tok_col,
                              line_count_next, column_count_next);
        else if (content_length_next == len_t'(KW_LEN) && kw_flags_next[1])
          res[res_n] = mk_res(KIND_EXTERN, '0, tok_line, tok_col,
                              line_count_next, column_count_next);
        else
          res[res_n] = mk_res(KIND_ATOM, cp_t'(content_length_next), tok_line, tok_col,
                              line_count_next, column_count_next);
        res_n = res_n + 2'd1;
        lex_mode_next = MODE_IDLE;
      end
    end

    // Idle: end of source, whitespace or the start of a new token.
    if (!done) begin
      lex_mode_next = MODE_IDLE;
      if (in_end) begin
        res[res_n] = mk_res(KIND_EOF, '0, line_count_next, column_count_next,
                            line_count_next, column_count_next);
        res_n = res_n + 2'd1;
      end else begin
        if (!is_space(in_cp)) begin
          tok_line_next = line_count_next;
          tok_col_next  = column_count_next;
        end
        if (column_count_next != '1) column_count_next = column_count_next + col_t'(1);
        if (in_cp == CP_NL) begin
          if (line_count_next != '1) line_count_next = line_count_next + line_t'(1);
          column_count_next = '0;
        end
        if (is_space(in_cp)) begin
          // Skipped without a result.
        end else if (is_punct(in_cp)) begin
          res[res_n] = mk_res(KIND_PUNCT, in_cp, tok_line_next, tok_col_next,
                              line_count_next, column_count_next);
          res_n = res_n + 2'd1;
        end else if (in_cp == CP_MINUS) begin
          lex_mode_next = MODE_MINUS;
        end else if (in_cp == CP_C) begin
          lex_mode_next = MODE_CPEND;
        end else if (in_cp == CP_USCORE || is_alpha(in_cp)) begin
          kw_flags_next = kw_update('0, 2'b11, in_cp);
          content_length_next = len_t'(1);
          res[res_n] = mk_res(KIND_WCHAR, in_cp, tok_line_next, tok_col_next,
                              line_count_next, column_count_next);
          res_n = res_n + 2'd1;
          lex_mode_next = MODE_WORD;
        end else begin
          res[res_n] = mk_res(KIND_UNPARS, in_cp, tok_line_next, tok_col_next,
                              line_count_next, column_count_next);
          res_n = res_n + 2'd1;
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_cp  <= s_tdata[CP_BITS-1:0];
      in_end <= s_tuser;
    end
  end

  // Scanner state, updated as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= MODE_IDLE;
      line_count     <= line_t'(1);
      column_count   <= '0;
      tok_line       <= line_t'(1);
      tok_col        <= '0;
      content_length <= '0;
      kw_flags       <= 2'b11;
    end else if (process) begin
      lex_mode       <= lex_mode_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      tok_line       <= tok_line_next;
      tok_col        <= tok_col_next;
      content_length <= content_length_next;
      kw_flags       <= kw_flags_next;
    end
  end

  // Result group: loaded with all results of an item, drained one a cycle while m_tready is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_cnt   <= 2'd0;
      grp_idx   <= 2'd0;
    end else if (process && res_n != 2'd0) begin
      grp_valid <= 1'b1;
      grp_cnt   <= res_n;
      grp_idx   <= 2'd0;
    end else if (grp_valid && m_tready) begin
      if (m_tlast) begin
        grp_valid <= 1'b0;
      end else begin
        grp_idx <= grp_idx + 2'd1;
      end
    end
    if (process && res_n != 2'd0) begin
      for (int i = 0; i < NRES; i++) grp[i] <= res[i];
    end
  end

  // The drain index always points at a loaded result.
  a_grp_index: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> (grp_cnt != 2'd0 && grp_idx < grp_cnt))
    else $error("result index outside the loaded group");

  // The line counter starts at one and never wraps to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line counter reached zero");

  // An item waiting for the result register keeps its contents.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !grp_free) |=> (in_valid && $stable(in_cp) && $stable(in_end)))
    else $error("pending item changed while blocked");

  // Taking the last result with nothing new to load empties the group.
  a_grp_drain: assert property (@(posedge clk) disable iff (rst)
    (grp_valid && m_tready && m_tlast && !(process && res_n != 2'd0)) |=> !grp_valid)
    else $error("result group not emptied after its last result");

  // End of source always gives at least one result.
  a_eof_result: assert property (@(posedge clk) disable iff (rst)
    (process && in_end) |=> grp_valid)
    else $error("end of source gave no result");

endmodule
